// ----- sv/tft_pkg.sv -----
// Shared types, sizes and helpers of the TCP flow tracker.
`default_nettype none

package tft_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int NUM_BANKS     = 8;
    localparam int BANK_DEPTH    = TABLE_ENTRIES / NUM_BANKS;
    localparam int ROW_W         = $clog2(BANK_DEPTH);
    localparam int BANK_W        = $clog2(NUM_BANKS);
    localparam int SCAN_W        = $clog2(BANK_DEPTH + 1);
    localparam int COUNT_WIDTH   = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic STATUS_CLOSED  = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  flag_bits;
        logic [47:0] timestamp_ms;
    } t_pkt;

    typedef struct packed {
        logic        status;
        logic [31:0] low_address;
        logic [15:0] low_port;
        logic [31:0] high_address;
        logic [15:0] high_port;
        logic [31:0] packets_in;
        logic [31:0] packets_out;
        logic [47:0] duration_ms;
    } t_result;

    // Classified request handed from the front part to the engine
    typedef struct packed {
        logic [31:0] low_address;
        logic [15:0] low_port;
        logic [31:0] high_address;
        logic [15:0] high_port;
        logic        is_out;
        logic        closing;
        logic [47:0] timestamp_ms;
    } t_req;

    typedef struct packed {
        logic [31:0] low_address;
        logic [15:0] low_port;
        logic [31:0] high_address;
        logic [15:0] high_port;
        t_count      count_in;
        t_count      count_out;
        logic [47:0] start_time;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    function automatic t_count sat_inc(input t_count v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    // Clip a stored count to the 32-bit report field
    function automatic logic [31:0] report_count(input t_count v);
        report_count = (v > t_count'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(v);
    endfunction

endpackage

`default_nettype wire

// ----- sv/tft_front.sv -----
// Front part: orders the endpoints and classifies each packet header.
`default_nettype none

module tft_front (
    input  wire logic          i_pkt_valid,
    input  wire tft_pkg::t_pkt i_pkt,
    output logic               o_pkt_stall,
    input  wire logic          i_q_full,
    output logic               o_push,
    output tft_pkg::t_req      o_req
);

    logic src_low;
    logic same_ends;

    always_comb begin
        src_low   = (i_pkt.source_address < i_pkt.dest_address) ||
                    ((i_pkt.source_address == i_pkt.dest_address) &&
                     (i_pkt.source_port < i_pkt.dest_port));
        same_ends = (i_pkt.source_address == i_pkt.dest_address) &&
                    (i_pkt.source_port == i_pkt.dest_port);

        o_req.low_address  = src_low ? i_pkt.source_address : i_pkt.dest_address;
        o_req.low_port     = src_low ? i_pkt.source_port    : i_pkt.dest_port;
        o_req.high_address = src_low ? i_pkt.dest_address   : i_pkt.source_address;
        o_req.high_port    = src_low ? i_pkt.dest_port      : i_pkt.source_port;
        // source equals the low endpoint: either it sorted low or both ends match
        o_req.is_out       = src_low || same_ends;
        o_req.closing      = i_pkt.flag_bits[0] || i_pkt.flag_bits[2];
        o_req.timestamp_ms = i_pkt.timestamp_ms;
    end

    assign o_pkt_stall = i_q_full;
    assign o_push      = i_pkt_valid && !i_q_full;

endmodule

`default_nettype wire

// ----- sv/tft_queue.sv -----
// Short request queue between the front part and the table engine.
`default_nettype none

module tft_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tft_pkg::t_req i_data,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output tft_pkg::t_req      o_data
);

    tft_pkg::t_req               r_slot [tft_pkg::QUEUE_DEPTH];
    logic [tft_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [tft_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [tft_pkg::QCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == tft_pkg::QCNT_W'(tft_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

endmodule

`default_nettype wire

// ----- sv/tft_engine.sv -----
// Back part: banked flow table, row scan, update and report register.
`default_nettype none

module tft_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    input  wire tft_pkg::t_req i_req,
    output logic               o_req_pop,
    output logic               o_res_valid,
    input  wire logic          i_res_stall,
    output tft_pkg::t_result   o_res
);

    tft_pkg::t_state r_state, n_state;
    tft_pkg::t_req   r_req;

    logic [tft_pkg::SCAN_W-1:0] r_cnt;
    logic                       r_rd_valid;
    logic [tft_pkg::ROW_W-1:0]  r_rd_row;
    tft_pkg::t_entry            r_rd_data [tft_pkg::NUM_BANKS];

    logic [tft_pkg::BANK_DEPTH-1:0][tft_pkg::NUM_BANKS-1:0] r_valid;

    logic                       r_hit;
    logic [tft_pkg::BANK_W-1:0] r_hit_bank;
    logic [tft_pkg::ROW_W-1:0]  r_hit_row;
    tft_pkg::t_entry            r_hit_entry;
    logic                       r_free;
    logic [tft_pkg::BANK_W-1:0] r_free_bank;
    logic [tft_pkg::ROW_W-1:0]  r_free_row;

    logic             r_res_valid;
    tft_pkg::t_result r_res;

    // scan signals
    logic                          issue;
    logic [tft_pkg::ROW_W-1:0]     rd_addr;
    logic [tft_pkg::NUM_BANKS-1:0] row_valid;
    logic [tft_pkg::NUM_BANKS-1:0] match;
    logic                          any_match;
    logic                          any_free;
    logic [tft_pkg::BANK_W-1:0]    match_bank;
    logic [tft_pkg::BANK_W-1:0]    free_bank;
    logic                          last_row;

    // update signals
    logic                       drop;
    logic                       need_report;
    logic                       out_ready;
    logic                       finish;
    logic                       mem_we;
    logic [tft_pkg::BANK_W-1:0] tgt_bank;
    logic [tft_pkg::ROW_W-1:0]  tgt_row;
    tft_pkg::t_entry            base;
    tft_pkg::t_entry            upd;
    tft_pkg::t_result           res;

    assign o_req_pop = (r_state == tft_pkg::S_IDLE) && i_req_valid;
    assign issue     = (r_state == tft_pkg::S_SCAN) &&
                       (r_cnt < tft_pkg::SCAN_W'(tft_pkg::BANK_DEPTH));
    assign rd_addr   = r_cnt[tft_pkg::ROW_W-1:0];
    assign last_row  = r_rd_valid && (r_rd_row == tft_pkg::ROW_W'(tft_pkg::BANK_DEPTH - 1));

    always_comb begin
        row_valid  = r_valid[r_rd_row];
        match_bank = '0;
        free_bank  = '0;
        for (int b = 0; b < tft_pkg::NUM_BANKS; b++) begin
            match[b] = row_valid[b] &&
                       (r_rd_data[b].low_address == r_req.low_address) &&
                       (r_rd_data[b].low_port == r_req.low_port) &&
                       (r_rd_data[b].high_address == r_req.high_address) &&
                       (r_rd_data[b].high_port == r_req.high_port);
        end
        // lowest bank wins within a row
        for (int b = tft_pkg::NUM_BANKS - 1; b >= 0; b--) begin
            if (match[b]) begin
                match_bank = tft_pkg::BANK_W'(b);
            end
            if (!row_valid[b]) begin
                free_bank = tft_pkg::BANK_W'(b);
            end
        end
        any_match = |match;
        any_free  = ~&row_valid;
    end

    // banked table storage
    for (genvar gb = 0; gb < tft_pkg::NUM_BANKS; gb++) begin : g_bank
        tft_pkg::t_entry r_mem [tft_pkg::BANK_DEPTH];

        always_ff @(posedge i_clk) begin
            if (mem_we && (tgt_bank == tft_pkg::BANK_W'(gb))) begin
                r_mem[tgt_row] <= upd;
            end
            if (issue) begin
                r_rd_data[gb] <= r_mem[rd_addr];
            end
        end
    end

    always_comb begin
        drop        = !r_hit && !r_free;
        need_report = drop || r_req.closing;
        out_ready   = !r_res_valid || !i_res_stall;
        finish      = (r_state == tft_pkg::S_UPDATE) && (!need_report || out_ready);
        mem_we      = finish && !drop && !r_req.closing;
        tgt_bank    = r_hit ? r_hit_bank : r_free_bank;
        tgt_row     = r_hit ? r_hit_row : r_free_row;

        if (r_hit) begin
            base = r_hit_entry;
        end else begin
            base.low_address  = r_req.low_address;
            base.low_port     = r_req.low_port;
            base.high_address = r_req.high_address;
            base.high_port    = r_req.high_port;
            base.count_in     = '0;
            base.count_out    = '0;
            base.start_time   = r_req.timestamp_ms;
        end

        upd = base;
        if (r_req.is_out) begin
            upd.count_out = tft_pkg::sat_inc(base.count_out);
        end else begin
            upd.count_in = tft_pkg::sat_inc(base.count_in);
        end

        res.low_address  = r_req.low_address;
        res.low_port     = r_req.low_port;
        res.high_address = r_req.high_address;
        res.high_port    = r_req.high_port;
        if (drop) begin
            res.status      = tft_pkg::STATUS_DROPPED;
            res.packets_in  = '0;
            res.packets_out = '0;
            res.duration_ms = '0;
        end else begin
            res.status      = tft_pkg::STATUS_CLOSED;
            res.packets_in  = tft_pkg::report_count(upd.count_in);
            res.packets_out = tft_pkg::report_count(upd.count_out);
            res.duration_ms = r_req.timestamp_ms - upd.start_time;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tft_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = tft_pkg::S_SCAN;
                end
            end
            tft_pkg::S_SCAN: begin
                if (last_row) begin
                    n_state = tft_pkg::S_UPDATE;
                end
            end
            tft_pkg::S_UPDATE: begin
                if (finish) begin
                    n_state = tft_pkg::S_IDLE;
                end
            end
            default: n_state = tft_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tft_pkg::S_IDLE;
            r_cnt       <= '0;
            r_rd_valid  <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_valid     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (o_req_pop) begin
                r_cnt      <= '0;
                r_rd_valid <= 1'b0;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
            end else if (r_state == tft_pkg::S_SCAN) begin
                if (issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                r_rd_valid <= issue;
                if (r_rd_valid && any_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (r_rd_valid && any_free && !r_free) begin
                    r_free <= 1'b1;
                end
            end

            // take the slot on a new or ongoing flow, free it on close
            if (finish && !drop) begin
                r_valid[tgt_row][tgt_bank] <= !r_req.closing;
            end

            if (finish && need_report) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_req <= i_req;
        end
        r_rd_row <= rd_addr;
        if (r_state == tft_pkg::S_SCAN && r_rd_valid) begin
            if (any_match && !r_hit) begin
                r_hit_bank  <= match_bank;
                r_hit_row   <= r_rd_row;
                r_hit_entry <= r_rd_data[match_bank];
            end
            if (any_free && !r_free) begin
                r_free_bank <= free_bank;
                r_free_row  <= r_rd_row;
            end
        end
        if (finish && need_report) begin
            r_res <= res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_pop_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_pop |=> (r_state == tft_pkg::S_SCAN))
        else $error("request pop did not start a table scan");

    a_read_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == tft_pkg::S_SCAN))
        else $error("table read data pending outside the scan");

    a_valid_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tft_pkg::S_UPDATE) |=> $stable(r_valid))
        else $error("slot valid bits changed outside the update step");

    a_hit_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == tft_pkg::S_UPDATE) && r_hit) |-> r_valid[r_hit_row][r_hit_bank])
        else $error("matched slot is not valid at update");

    a_report_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> ($past(r_state) == tft_pkg::S_UPDATE))
        else $error("report raised outside the update step");

endmodule

`default_nettype wire

// ----- sv/tcp_flow_tracker.sv -----
// The engine takes one request at a time and works through it in the steps of the row scan
// of the 8-bank flow table: a pop, 8 row reads plus registered read data, and an update that
// writes the table or registers a report; a report waits for the output to be free.
// A 2-entry queue takes new requests while the engine works and while a report waits.
// Reset clears the slot valid bits, the queue and the report valid flag;
// requests are taken from the first cycle after reset.
`default_nettype none

module tcp_flow_tracker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_pkt_valid,
    input  wire tft_pkg::t_pkt i_pkt,
    output logic               o_pkt_stall,
    output logic               o_res_valid,
    input  wire logic          i_res_stall,
    output tft_pkg::t_result   o_res
);

    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    tft_pkg::t_req front_req;
    tft_pkg::t_req q_req;

    tft_front u_front (
        .i_pkt_valid (i_pkt_valid),
        .i_pkt       (i_pkt),
        .o_pkt_stall (o_pkt_stall),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_req       (front_req)
    );

    tft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_req)
    );

    tft_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (q_valid),
        .i_req       (q_req),
        .o_req_pop   (q_pop),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
